// ===== src/sli_pkg.sv =====
// Package for the sorted list block: item types, command and status codes.
// Used by sli_cell and sorted_list_insert_delete.
package sli_pkg;

    localparam int VALUE_W      = 12;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_READ    = 2'd2,
        CMD_REPLACE = 2'd3
    } sli_cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } sli_status_t;

    typedef struct packed {
        sli_cmd_t             command;
        logic [VALUE_W-1:0]   value;
        logic [INDEX_W-1:0]   index;
    } sli_req_t;

    typedef struct packed {
        sli_status_t          status;
        logic [COUNT_W-1:0]   count;
        logic [VALUE_W-1:0]   read_value;
    } sli_res_t;

    // Broadcast controls for the cell row; flags are already gated by accept.
    typedef struct packed {
        logic                 rem_val;
        logic                 rem_pos;
        logic                 ins;
        logic [VALUE_W-1:0]   value;
        logic [INDEX_W-1:0]   index;
    } sli_ctrl_t;

endpackage

// ===== src/sli_cell.sv =====
// One list entry of the sorted list row: compare, remove shift and insert shift.
// Depends on sli_pkg.
module sli_cell #(
    parameter int POS   = 0,
    parameter int CNT_W = 7,
    parameter int CMP_W = 7
) (
    input  logic                          clk,
    input  sli_pkg::sli_ctrl_t            ctrl,
    input  logic [CNT_W-1:0]              count,
    input  logic [CNT_W-1:0]              count1,
    input  logic [sli_pkg::VALUE_W-1:0]   right_entry,
    input  logic [sli_pkg::VALUE_W-1:0]   left_r,
    input  logic                          left_after,
    output logic [sli_pkg::VALUE_W-1:0]   entry,
    output logic [sli_pkg::VALUE_W-1:0]   r,
    output logic                          after,
    output logic                          hit,
    output logic [sli_pkg::VALUE_W-1:0]   rd
);

    logic [sli_pkg::VALUE_W-1:0] entry_reg;
    logic [sli_pkg::VALUE_W-1:0] entry_next;
    logic                        valid;
    logic                        valid1;
    logic                        ge;
    logic                        rem;
    logic                        at_or_past_idx;
    logic                        at_idx;

    always_comb
    begin
        valid          = CNT_W'(POS) < count;
        ge             = valid && (entry_reg >= ctrl.value);
        hit            = valid && (entry_reg == ctrl.value);
        at_or_past_idx = CMP_W'(POS) >= CMP_W'(ctrl.index);
        at_idx         = CMP_W'(POS) == CMP_W'(ctrl.index);
        rem            = (ctrl.rem_val && ge) || (ctrl.rem_pos && at_or_past_idx);
        r              = rem ? right_entry : entry_reg;
        valid1         = CNT_W'(POS) < count1;
        after          = !valid1 || (r > ctrl.value);
        if (ctrl.ins)
        begin
            if (after)
                entry_next = left_after ? left_r : ctrl.value;
            else
                entry_next = r;
        end
        else
        begin
            entry_next = r;
        end
        rd = at_idx ? entry_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins || ctrl.rem_val || ctrl.rem_pos)
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== src/sorted_list_insert_delete.sv =====
// Sorted list: a row of sli_cell entries kept in ascending order.
// The result is valid in the cycle after the item is accepted; one item per cycle sustained
// while the result is unloaded, set by the combinational compare and shift in each cell of the row.
// A result register holds the result; a new item is taken while it is unloaded.
// Reset clears the entry count and result valid; entry contents are not reset.
// Depends on sli_pkg and sli_cell.
module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sli_pkg::sli_req_t req,
    output logic              res_valid,
    input  logic              res_ready,
    output sli_pkg::sli_res_t res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > sli_pkg::INDEX_W) ? CNT_W : sli_pkg::INDEX_W;

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W-1:0]            count1;
    logic                        res_valid_reg;
    sli_pkg::sli_res_t           res_reg;
    sli_pkg::sli_res_t           res_next;
    sli_pkg::sli_ctrl_t          ctrl;
    logic                        accept;
    logic                        full;
    logic                        in_range;
    logic                        found;
    logic [sli_pkg::VALUE_W-1:0] rd_sel;

    logic [sli_pkg::VALUE_W-1:0] entry_w [CAPACITY];
    logic [sli_pkg::VALUE_W-1:0] r_w     [CAPACITY];
    logic [sli_pkg::VALUE_W-1:0] rd_w    [CAPACITY];
    logic [CAPACITY-1:0]         after_w;
    logic [CAPACITY-1:0]         hit_w;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [sli_pkg::VALUE_W-1:0] right_e;
            logic [sli_pkg::VALUE_W-1:0] left_r;
            logic                        left_a;
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = entry_w[g+1];
            end
            if (g == 0)
            begin : g_first
                assign left_r = '0;
                assign left_a = 1'b0;
            end
            else
            begin : g_rest
                assign left_r = r_w[g-1];
                assign left_a = after_w[g-1];
            end
            sli_cell #(
                .POS   (g),
                .CNT_W (CNT_W),
                .CMP_W (CMP_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .count1      (count1),
                .right_entry (right_e),
                .left_r      (left_r),
                .left_after  (left_a),
                .entry       (entry_w[g]),
                .r           (r_w[g]),
                .after       (after_w[g]),
                .hit         (hit_w[g]),
                .rd          (rd_w[g])
            );
        end
    endgenerate

    assign req_ready = !res_valid_reg || res_ready;
    assign accept    = req_valid && req_ready;
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign in_range  = CMP_W'(req.index) < CMP_W'(count_reg);
    assign found     = |hit_w;

    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_sel = rd_sel | rd_w[i];
    end

    always_comb
    begin
        ctrl.rem_val = 1'b0;
        ctrl.rem_pos = 1'b0;
        ctrl.ins     = 1'b0;
        ctrl.value   = req.value;
        ctrl.index   = req.index;
        count_next   = count_reg;
        res_next.status     = sli_pkg::ST_OK;
        res_next.read_value = '0;
        case (req.command)
            sli_pkg::CMD_INSERT:
            begin
                if (full)
                    res_next.status = sli_pkg::ST_FULL;
                else
                begin
                    ctrl.ins   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            sli_pkg::CMD_DELETE:
            begin
                if (found)
                begin
                    ctrl.rem_val = accept;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                    res_next.status = sli_pkg::ST_NOT_FOUND;
            end
            sli_pkg::CMD_READ:
            begin
                if (in_range)
                    res_next.read_value = rd_sel;
                else
                    res_next.status = sli_pkg::ST_RANGE;
            end
            sli_pkg::CMD_REPLACE:
            begin
                if (in_range)
                begin
                    ctrl.rem_pos = accept;
                    ctrl.ins     = accept;
                end
                else
                    res_next.status = sli_pkg::ST_RANGE;
            end
            default:
            begin
                res_next.status = sli_pkg::ST_RANGE;
            end
        endcase
        count1         = count_reg - CNT_W'(ctrl.rem_val || ctrl.rem_pos);
        res_next.count = sli_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== test/sorted_list_insert_delete_tb.sv =====
// Testbench for sorted_list_insert_delete: directed, fill/drain and random command items
// checked against an in-bench queue model of the sorted list, with random source/sink stalls.
// Depends on sli_pkg and the sorted_list_insert_delete RTL.
module sorted_list_insert_delete_tb;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    sli_pkg::sli_req_t req = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    sli_pkg::sli_res_t res;

    logic [sli_pkg::VALUE_W-1:0] model_list[$];
    sli_pkg::sli_res_t           expected_results[$];
    int                          err_count = 0;
    int                          burst_left = 0;
    int                          cmd_seen[4];
    int                          status_seen[4];
    int                          rx_cycle = 0;
    int                          rx_mode = 0;

    sorted_list_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("sorted_list_insert_delete_tb NOT OK");
        $finish;
    end

    // sink stall pattern, re-chosen at random from four modes
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= ($urandom_range(0, 3) != 0);
            2: res_ready <= ($urandom_range(0, 3) == 0);
            default: res_ready <= rx_cycle[2];
        endcase
    end

    always @(posedge clk)
    begin : check_results
        sli_pkg::sli_res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: status %0d count %0d read_value %0d",
                             res.status, res.count, res.read_value);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res.status !== want.status || res.count !== want.count ||
                    res.read_value !== want.read_value)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: expected status %0d count %0d read_value %0d,",
                                  " got status %0d count %0d read_value %0d"},
                                 want.status, want.count, want.read_value,
                                 res.status, res.count, res.read_value);
                end
            end
        end
    end

    function automatic void insert_in_order(logic [sli_pkg::VALUE_W-1:0] v);
        int pos;
        pos = 0;
        while (pos < model_list.size() && model_list[pos] <= v)
            pos++;
        model_list.insert(pos, v);
    endfunction

    function automatic sli_pkg::sli_res_t apply_list_op(sli_pkg::sli_req_t item);
        sli_pkg::sli_res_t r;
        int                pos;
        r.status = sli_pkg::ST_OK;
        r.read_value = '0;
        case (item.command)
            sli_pkg::CMD_INSERT:
                if (model_list.size() >= sli_pkg::CAPACITY_DEF)
                    r.status = sli_pkg::ST_FULL;
                else
                    insert_in_order(item.value);
            sli_pkg::CMD_DELETE:
            begin
                pos = 0;
                while (pos < model_list.size() && model_list[pos] != item.value)
                    pos++;
                if (pos < model_list.size())
                    model_list.delete(pos);
                else
                    r.status = sli_pkg::ST_NOT_FOUND;
            end
            sli_pkg::CMD_READ:
                if (item.index < model_list.size())
                    r.read_value = model_list[item.index];
                else
                    r.status = sli_pkg::ST_RANGE;
            default:
                if (item.index < model_list.size())
                begin
                    model_list.delete(item.index);
                    insert_in_order(item.value);
                end
                else
                    r.status = sli_pkg::ST_RANGE;
        endcase
        r.count = sli_pkg::COUNT_W'(model_list.size());
        return r;
    endfunction

    function automatic sli_pkg::sli_req_t make_item(sli_pkg::sli_cmd_t cmd, int v, int idx);
        sli_pkg::sli_req_t item;
        item.command = cmd;
        item.value = sli_pkg::VALUE_W'(v);
        item.index = sli_pkg::INDEX_W'(idx);
        return item;
    endfunction

    // mix of full range, extremes/clusters and values already held
    function automatic logic [sli_pkg::VALUE_W-1:0] pick_position_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15 && model_list.size() > 0)
            return model_list[$urandom_range(0, model_list.size() - 1)];
        if (r < 30)
            return sli_pkg::VALUE_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                          : $urandom_range(4088, 4095));
        return sli_pkg::VALUE_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [sli_pkg::INDEX_W-1:0] pick_index();
        if (model_list.size() > 0 && $urandom_range(0, 99) < 85)
            return sli_pkg::INDEX_W'($urandom_range(0, model_list.size() - 1));
        return sli_pkg::INDEX_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [sli_pkg::VALUE_W-1:0] pick_delete_value();
        if (model_list.size() > 0 && $urandom_range(0, 99) < 80)
            return model_list[$urandom_range(0, model_list.size() - 1)];
        return pick_position_value();
    endfunction

    task automatic send_item(input sli_pkg::sli_req_t item);
        sli_pkg::sli_res_t predicted;
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_list_op(item);
        expected_results.push_back(predicted);
        cmd_seen[item.command]++;
        status_seen[predicted.status]++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                                    : $urandom_range(20, 60);
        end
    endtask

    task automatic test_directed();
        send_item(make_item(sli_pkg::CMD_READ, 0, 0));
        send_item(make_item(sli_pkg::CMD_DELETE, 0, 0));
        send_item(make_item(sli_pkg::CMD_REPLACE, 5, 0));
        send_item(make_item(sli_pkg::CMD_INSERT, 4095, 0));
        send_item(make_item(sli_pkg::CMD_INSERT, 0, 63));
        send_item(make_item(sli_pkg::CMD_INSERT, 2048, 0));
        send_item(make_item(sli_pkg::CMD_INSERT, 2048, 0));
        send_item(make_item(sli_pkg::CMD_INSERT, 2049, 0));
        send_item(make_item(sli_pkg::CMD_READ, 0, 0));
        send_item(make_item(sli_pkg::CMD_READ, 0, 4));
        send_item(make_item(sli_pkg::CMD_READ, 0, 5));
        send_item(make_item(sli_pkg::CMD_READ, 4095, 63));
        send_item(make_item(sli_pkg::CMD_DELETE, 2048, 0));
        send_item(make_item(sli_pkg::CMD_DELETE, 7, 0));
        send_item(make_item(sli_pkg::CMD_REPLACE, 4095, 0));
        send_item(make_item(sli_pkg::CMD_REPLACE, 0, 3));
        send_item(make_item(sli_pkg::CMD_READ, 0, 3));
        send_item(make_item(sli_pkg::CMD_READ, 0, 0));
        send_item(make_item(sli_pkg::CMD_DELETE, 4095, 0));
        send_item(make_item(sli_pkg::CMD_DELETE, 4095, 0));
        send_item(make_item(sli_pkg::CMD_DELETE, 0, 0));
        send_item(make_item(sli_pkg::CMD_DELETE, 2049, 0));
        send_item(make_item(sli_pkg::CMD_DELETE, 2049, 0));
        send_item(make_item(sli_pkg::CMD_READ, 0, 0));
    endtask

    // fill to capacity, exercise the full list, then empty it again
    task automatic test_fill_and_drain();
        repeat (2)
        begin
            while (model_list.size() < sli_pkg::CAPACITY_DEF)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_item(sli_pkg::CMD_READ, pick_position_value(),
                                        pick_index()));
                else
                    send_item(make_item(sli_pkg::CMD_INSERT, pick_position_value(),
                                        pick_index()));
            end
            repeat (3)
                send_item(make_item(sli_pkg::CMD_INSERT, pick_position_value(), pick_index()));
            send_item(make_item(sli_pkg::CMD_REPLACE, 0, 63));
            send_item(make_item(sli_pkg::CMD_REPLACE, 4095, 0));
            repeat (3)
                send_item(make_item(sli_pkg::CMD_REPLACE, pick_position_value(), pick_index()));
            send_item(make_item(sli_pkg::CMD_READ, 0, 63));
            send_item(make_item(sli_pkg::CMD_READ, 0, 0));
            send_item(make_item(sli_pkg::CMD_INSERT, 4095, 63));
            while (model_list.size() > 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_item(sli_pkg::CMD_READ, 0, pick_index()));
                else
                    send_item(make_item(sli_pkg::CMD_DELETE, pick_delete_value(),
                                        pick_index()));
            end
        end
    endtask

    // weighted command mix; insert/delete bias swaps every 100 items
    task automatic test_random_mix(input int n_items);
        int                r;
        int                ins_weight;
        sli_pkg::sli_cmd_t cmd;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 100 == 0)
                ins_weight = ((n / 100) % 2 == 0) ? 55 : 20;
            r = $urandom_range(0, 99);
            if (r < ins_weight)
                cmd = sli_pkg::CMD_INSERT;
            else if (r < 75)
                cmd = sli_pkg::CMD_DELETE;
            else if (r < 88)
                cmd = sli_pkg::CMD_READ;
            else
                cmd = sli_pkg::CMD_REPLACE;
            if (cmd == sli_pkg::CMD_DELETE)
                send_item(make_item(cmd, pick_delete_value(), pick_index()));
            else
                send_item(make_item(cmd, pick_position_value(), pick_index()));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_drain();
        test_random_mix(900);
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("items: %0d insert, %0d delete, %0d read, %0d replace",
                 cmd_seen[sli_pkg::CMD_INSERT], cmd_seen[sli_pkg::CMD_DELETE],
                 cmd_seen[sli_pkg::CMD_READ], cmd_seen[sli_pkg::CMD_REPLACE]);
        $display("status: %0d ok, %0d not found, %0d full, %0d out of range; %0d errors",
                 status_seen[sli_pkg::ST_OK], status_seen[sli_pkg::ST_NOT_FOUND],
                 status_seen[sli_pkg::ST_FULL], status_seen[sli_pkg::ST_RANGE], err_count);
        if (err_count == 0)
            $display("sorted_list_insert_delete_tb OK");
        else
            $display("sorted_list_insert_delete_tb NOT OK");
        $finish;
    end

endmodule

// ===== sorted_list_insert_delete.f =====
src/sli_pkg.sv
src/sli_cell.sv
src/sorted_list_insert_delete.sv
test/sorted_list_insert_delete_tb.sv
